// ===== hdl/merge_insertion_sorter_macros.svh =====
// Assertion macros for the merge-insertion sorter.
// Used by the top level; depends on signals named clk and rst_n in scope.
`ifndef MERGE_INSERTION_SORTER_MACROS_SVH
`define MERGE_INSERTION_SORTER_MACROS_SVH
`ifndef SYNTHESIS
`define MSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sorter assertion failed");
`define MSR_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter implication failed");
`else
`define MSR_ASSERT(lbl, prop)
`define MSR_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== hdl/msort_pkg.sv =====
// Package for the merge-insertion sorter: default sizes and the sequencer states.
// No dependencies.
package msort_pkg;
  localparam int MAX_ITEMS_DEF = 1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_KEY,
    ST_BS_RD,
    ST_BS_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_NEXT,
    ST_RD_ISSUE,
    ST_RD_DATA
  } msort_state_t;
endpackage

// ===== hdl/msort_if.sv =====
// Valid/ready channel interfaces for the sorter's input and result items.
// No dependencies.
interface msort_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface msort_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               last;
  logic               overflow;
  modport source (output valid, output sorted_value, output last, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last, input overflow,
                output ready);
endinterface

// ===== hdl/merge_insertion_sorter.sv =====
// Merge-insertion sorter top level: load store, chain memory and sequencer.
// Depends on msort_pkg, msort_if.sv and merge_insertion_sorter_macros.svh.
//
//  channel | direction | payload
//  in_s    | sink      | op, value
//  out_s   | source    | sorted_value, last, overflow
//
// A load writes the value into the load store. The first read after loading
// sorts by binary insertion into the chain memory: per value a binary search
// of the chain, then each larger entry is read and written one place up.
// Reset clears only the state, the counters and the flags.
// No item is taken while a result waits in the output register.
`include "merge_insertion_sorter_macros.svh"
module merge_insertion_sorter
  import msort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  msort_in_if.sink    in_s,
  msort_out_if.source out_s
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [31:0] ls_mem [MAX_ITEMS];
  logic signed [31:0] ch_mem [MAX_ITEMS];
  logic signed [31:0] ls_rdata_r, ch_rdata_r;

  msort_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, rp_r, rp_nxt, k_r, k_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt, mid;
  logic          sorted_r, sorted_nxt, ovf_r, ovf_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic signed [31:0] out_val_r, out_val_nxt;

  logic          ls_we, ch_we;
  logic [AW-1:0] ls_raddr, ch_raddr, ch_waddr;
  logic signed [31:0] ch_wdata;
  logic          acc;

  assign in_s.ready         = (state_r == ST_IDLE) && !out_valid_r;
  assign acc                = in_s.valid && in_s.ready;
  assign mid                = lo_r + ((hi_r - lo_r) >> 1);
  assign out_s.valid        = out_valid_r;
  assign out_s.sorted_value = out_val_r;
  assign out_s.last         = out_last_r;
  assign out_s.overflow     = out_ovf_r;

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[cnt_r[AW-1:0]] <= in_s.value;
    end
    ls_rdata_r <= ls_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    ch_rdata_r <= ch_mem[ch_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    sorted_nxt    = sorted_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_s.ready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ls_we         = 1'b0;
    ch_we         = 1'b0;
    ls_raddr      = k_r[AW-1:0];
    ch_raddr      = mid[AW-1:0];
    ch_waddr      = j_r[AW-1:0];
    ch_wdata      = ch_rdata_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (!in_s.op) begin
            if (cnt_r >= CW'(MAX_ITEMS)) begin
              ovf_nxt       = 1'b1;
              out_valid_nxt = 1'b1;
              out_val_nxt   = '0;
              out_last_nxt  = 1'b0;
              out_ovf_nxt   = 1'b1;
            end else begin
              ls_we      = 1'b1;
              cnt_nxt    = cnt_r + 1'b1;
              sorted_nxt = 1'b0;
              rp_nxt     = '0;
            end
          end else if (cnt_r != '0) begin
            if (!sorted_r) begin
              k_nxt     = '0;
              state_nxt = ST_FETCH;
            end else if (rp_r < cnt_r) begin
              state_nxt = ST_RD_ISSUE;
            end
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_KEY;
      end
      ST_KEY: begin
        key_nxt   = ls_rdata_r;
        lo_nxt    = '0;
        hi_nxt    = k_r;
        state_nxt = ST_BS_RD;
      end
      ST_BS_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_BS_CMP;
        end else begin
          j_nxt     = k_r;
          state_nxt = ST_SH_RD;
        end
      end
      ST_BS_CMP: begin
        if (ch_rdata_r < key_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = ST_BS_RD;
      end
      ST_SH_RD: begin
        ch_raddr = AW'(j_r - 1'b1);
        if (j_r > lo_r) begin
          state_nxt = ST_SH_WR;
        end else begin
          ch_we     = 1'b1;
          ch_waddr  = lo_r[AW-1:0];
          ch_wdata  = key_r;
          state_nxt = ST_NEXT;
        end
      end
      ST_SH_WR: begin
        ch_we     = 1'b1;
        j_nxt     = j_r - 1'b1;
        state_nxt = ST_SH_RD;
      end
      ST_NEXT: begin
        k_nxt    = k_r + 1'b1;
        ls_raddr = AW'(k_r + 1'b1);
        if (k_r + 1'b1 == cnt_r) begin
          sorted_nxt = 1'b1;
          rp_nxt     = '0;
          state_nxt  = ST_RD_ISSUE;
        end else begin
          state_nxt = ST_KEY;
        end
      end
      ST_RD_ISSUE: begin
        ch_raddr  = rp_r[AW-1:0];
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = ch_rdata_r;
        out_last_nxt  = (rp_r + 1'b1 == cnt_r);
        out_ovf_nxt   = ovf_r;
        rp_nxt        = rp_r + 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rp_r        <= '0;
      sorted_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rp_r        <= rp_nxt;
      sorted_r    <= sorted_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  `MSR_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_ITEMS))
  `MSR_IMPLY(a_last_at_end, out_valid_r && out_last_r && !out_ovf_r, rp_r == cnt_r)
  `MSR_IMPLY(a_shift_above_lo, state_r == ST_SH_WR, j_r > lo_r)
  `MSR_IMPLY(a_sort_restarts_read, $rose(sorted_r), rp_r == '0)
endmodule

// ===== sim/tb_merge_insertion_sorter.sv =====
// Self-checking testbench for merge_insertion_sorter: a directed table, random load
// and read bursts under varying idling, then a full store with overflowed loads,
// checked against an in-bench sort model. Depends on msort_pkg and msort_if.sv.
`timescale 1ns / 100ps
module tb_merge_insertion_sorter
  import msort_pkg::*;
();

  localparam int CAP = MAX_ITEMS_DEF;
  localparam int PEND_CAP = (CAP + 1) / 2;
  localparam int JACOB_CAP = 47;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam longint CYCLE_LIMIT = 60000000;
  localparam int FINAL_READS = 275;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last;
    logic               overflow;
  } sort_res_t;

  typedef struct {
    logic               op;
    logic signed [31:0] value;
    bit                 typed;
    sort_res_t          res;
  } table_row_t;

  logic clk;
  logic rst_n;
  msort_in_if  in_ch();
  msort_out_if out_ch();

  merge_insertion_sorter dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  bit [31:0]   load_mem [CAP];
  bit [31:0]   chain_mem [CAP];
  bit [31:0]   pend_mem [PEND_CAP];
  int unsigned order_mem [PEND_CAP];
  int unsigned stored_cnt;
  int unsigned rd_ptr;
  bit          is_sorted;
  bit          ovf_sticky;

  sort_res_t   pending_q[$];
  table_row_t  directed [$];
  int          errors;
  int          sent;
  int          results_seen;
  int          tx_idle;
  int          rx_idle;
  longint      cycles = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ch.ready <= ($urandom_range(99) >= rx_idle);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[merge_insertion_sorter] ERROR");
      $finish;
    end
  end

  function automatic void add_row(input logic op, input logic [31:0] value,
                                  input bit typed, input sort_res_t res);
    table_row_t r;
    r.op = op;
    r.value = value;
    r.typed = typed;
    r.res = res;
    directed.insert(directed.size(), r);
  endfunction

  function automatic int unsigned make_order(int unsigned size);
    int unsigned m, prev, pp, nb, i;
    m = 0;
    prev = 1;
    pp = 0;
    nb = 0;
    while (nb < size && nb < JACOB_CAP) begin
      nb = prev + 2 * pp;
      if (nb > size) nb = size;
      if (m < PEND_CAP) begin
        order_mem[m] = nb;
        m++;
      end
      pp = prev;
      prev = nb;
      for (i = nb - 1; i > pp; i--) begin
        if (m < PEND_CAP) begin
          order_mem[m] = i;
          m++;
        end
      end
    end
    return m;
  endfunction

  function automatic void chain_insert(ref int unsigned len, input bit [31:0] key);
    int unsigned lo, hi, mid, i;
    lo = 0;
    hi = len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (chain_mem[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (len >= CAP) return;
    for (i = len; i > lo; i--) chain_mem[i] = chain_mem[i - 1];
    chain_mem[lo] = key;
    len++;
  endfunction

  function automatic void sort_store();
    int unsigned n, np, npend, len, m, k, j, idx;
    bit [31:0] a, b, t;
    n = stored_cnt;
    np = n / 2;
    for (k = 0; k < np; k++) begin
      a = load_mem[2 * k];
      b = load_mem[2 * k + 1];
      if (b > a) begin
        chain_mem[k] = b;
        pend_mem[k] = a;
      end else begin
        chain_mem[k] = a;
        pend_mem[k] = b;
      end
      for (j = k; j > 0 && chain_mem[j] < chain_mem[j - 1]; j--) begin
        t = chain_mem[j]; chain_mem[j] = chain_mem[j - 1]; chain_mem[j - 1] = t;
        t = pend_mem[j]; pend_mem[j] = pend_mem[j - 1]; pend_mem[j - 1] = t;
      end
    end
    npend = np;
    if (n[0] && npend < PEND_CAP) begin
      pend_mem[npend] = load_mem[n - 1];
      npend++;
    end
    len = np;
    m = make_order(npend);
    for (k = 0; k < npend; k++) begin
      idx = (k < m) ? order_mem[k] - 1 : k;
      if (idx >= npend) idx = k;
      chain_insert(len, pend_mem[idx]);
    end
  endfunction

  // Returns 1 and the expected result when the item gives one.
  function automatic bit predict_sort(input logic op, input logic [31:0] value,
                                      output sort_res_t res);
    res = '0;
    if (op == OP_LOAD) begin
      if (stored_cnt >= CAP) begin
        ovf_sticky = 1'b1;
        res.overflow = 1'b1;
        return 1'b1;
      end
      load_mem[stored_cnt] = value ^ 32'h8000_0000;
      stored_cnt++;
      is_sorted = 1'b0;
      rd_ptr = 0;
      return 1'b0;
    end
    if (stored_cnt == 0) return 1'b0;
    if (!is_sorted) begin
      sort_store();
      is_sorted = 1'b1;
      rd_ptr = 0;
    end
    if (rd_ptr >= stored_cnt) return 1'b0;
    res.sorted_value = chain_mem[rd_ptr] ^ 32'h8000_0000;
    res.last = (rd_ptr + 1 == stored_cnt);
    res.overflow = ovf_sticky;
    rd_ptr++;
    return 1'b1;
  endfunction

  task automatic send_item(input logic op, input logic [31:0] value,
                           input bit typed, input sort_res_t typed_res);
    bit acc;
    bit has;
    sort_res_t res;
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.value <= value;
    do begin
      @(negedge clk);
      acc = in_ch.valid && in_ch.ready;
      if (acc) begin
        sent++;
        has = predict_sort(op, value, res);
        if (has) pending_q.insert(pending_q.size(), typed ? typed_res : res);
      end
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_bursts(input int target);
    int i, burst, reads;
    sort_res_t none;
    none = '0;
    while (sent < target) begin
      burst = $urandom_range(1, 4);
      for (i = 0; i < burst; i++) send_item(OP_LOAD, $urandom, 1'b0, none);
      reads = $urandom_range(0, 8);
      for (i = 0; i < reads; i++) send_item(OP_READ, $urandom, 1'b0, none);
    end
  endtask

  always @(negedge clk) begin
    sort_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d last %0b ovf %0b",
                 $time, out_ch.sorted_value, out_ch.last, out_ch.overflow);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.sorted_value !== want.sorted_value) begin
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   want.sorted_value, out_ch.sorted_value);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
          errors++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                   out_ch.overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    sort_res_t none;
    table_row_t row;
    int i;
    none = '0;
    errors = 0;
    sent = 0;
    results_seen = 0;
    stored_cnt = 0;
    rd_ptr = 0;
    is_sorted = 1'b0;
    ovf_sticky = 1'b0;
    tx_idle = 37;
    rx_idle = 87;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_LOAD;
    in_ch.value <= '0;

    // Empty-store read, extremes loaded high first, more loads and reads past the end.
    add_row(OP_READ, 32'sd0, 1'b0, none);
    add_row(OP_LOAD, 32'h7FFF_FFFF, 1'b0, none);
    add_row(OP_LOAD, 32'h8000_0000, 1'b0, none);
    add_row(OP_READ, 32'sd0, 1'b1, sort_res_t'{32'h8000_0000, 1'b0, 1'b0});
    add_row(OP_READ, 32'hFFFF_FFFF, 1'b1, sort_res_t'{32'h7FFF_FFFF, 1'b1, 1'b0});
    add_row(OP_READ, 32'sd0, 1'b0, none);
    add_row(OP_LOAD, 32'sd0, 1'b0, none);
    add_row(OP_LOAD, -32'sd1, 1'b0, none);
    add_row(OP_LOAD, 32'sd1, 1'b0, none);
    add_row(OP_READ, 32'sd0, 1'b0, none);
    add_row(OP_LOAD, 32'h5555_5555, 1'b0, none);
    add_row(OP_LOAD, 32'hAAAA_AAAA, 1'b0, none);
    add_row(OP_LOAD, 32'sd7, 1'b0, none);
    add_row(OP_LOAD, 32'sd7, 1'b0, none);
    for (i = 0; i < 11; i++) add_row(OP_READ, 32'sd0, 1'b0, none);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed.size(); i++) begin
      row = directed[i];
      send_item(row.op, row.value, row.typed, row.res);
    end
    random_bursts(200);
    drain(100);

    tx_idle = 87;
    rx_idle = 37;
    random_bursts(400);
    drain(100);

    tx_idle = 0;
    rx_idle = 0;
    random_bursts(560);
    drain(100);

    // Fill the store, overflow it, then read the lowest part of the sorted store.
    while (stored_cnt < CAP) send_item(OP_LOAD, $urandom, 1'b0, none);
    for (i = 0; i < 3; i++) begin
      send_item(OP_LOAD, $urandom, 1'b1, sort_res_t'{32'sd0, 1'b0, 1'b1});
    end
    for (i = 0; i < FINAL_READS; i++) send_item(OP_READ, $urandom, 1'b0, none);
    drain(200);

    $display("covered %0d items and %0d results over three idling phases,",
             sent, results_seen);
    $display("ending with a full store, overflowed loads and a sorted read-out");
    if (errors == 0) begin
      $display("[merge_insertion_sorter] OK");
    end else begin
      $display("[merge_insertion_sorter] ERROR");
    end
    $finish;
  end
endmodule
